// ===== rtl/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// swa_pkg
// Shared widths, constants and types for the sliding window average block.
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int SAMPLE_W   = 32;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int REM_W      = WIN_W + 1;
  localparam int DIV_STEPS  = SUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [WIN_W-1:0]    win_t;
  typedef logic [PTR_W-1:0]    ptr_t;

  typedef struct packed {
    logic  start;
    sum_t  dividend;
    win_t  divisor;
  } div_req_t;

  typedef struct packed {
    logic    done;
    sample_t quotient;
  } div_rsp_t;

  // Zero means a window of one; anything beyond the ring depth saturates.
  function automatic win_t win_eff(input win_t raw);
    win_t w;
    begin
      w = raw;
      if (raw == '0) begin
        w = win_t'(1);
      end else if (raw > win_t'(MAX_WINDOW)) begin
        w = win_t'(MAX_WINDOW);
      end
      return w;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/swa_div.sv =====
// ----------------------------------------------------------------------------
// swa_div
// Restoring divider, one quotient bit per cycle, for the window sum.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire swa_pkg::div_req_t req,
  output swa_pkg::div_rsp_t      rsp
);
  import swa_pkg::*;

  sum_t              dq_r, dq_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  win_t              dvs_r, dvs_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign rem_sh = {rem_r[REM_W-2:0], dq_r[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dq_nxt  = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = STEP_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
      dq_nxt   = {dq_r[SUM_W-2:0], fits};
      cnt_nxt  = cnt_r - STEP_W'(1);
      done_nxt = (cnt_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // The mean never exceeds the largest sample, so the low bits hold it all.
  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r[SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/sliding_window_average.sv =====
// A transaction that fills the window passes the ring read, the sum update and
// the 40-step bit-serial divider before its result is registered; one that
// yields no result returns to idle after the sum update. One transaction at a
// time: the input stalls until the block is through with the current one.
// Reset (rst_n, synchronous, active low) clears the sum, fill count and pointer
// and sets the window length to 4; ring contents are not cleared.
// ----------------------------------------------------------------------------
// sliding_window_average
// Moving average over a ring of recent samples with a running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_average (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire swa_pkg::sample_t      in_price,
  input  wire logic                  in_series_start,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      swa_pkg::sample_t      out_average,
  input  wire logic                  cfg_wr_en,
  input  wire swa_pkg::win_t         cfg_wr_data
);
  import swa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  sample_t    ring_mem [MAX_WINDOW];
  sample_t    rd_data_r;

  logic [1:0] state_r, state_nxt;
  win_t       win_r, win_nxt;
  sum_t       sum_r, sum_nxt;
  win_t       fill_r, fill_nxt;
  ptr_t       wp_r, wp_nxt;
  sample_t    sample_r;
  logic       start_r;
  logic       sub_r;
  logic       emit_r;
  logic       out_valid_r, out_valid_nxt;
  sample_t    out_avg_r;

  logic       accept;
  logic       out_free;
  logic       load_out;
  win_t       fill_base;
  logic       sub_now;
  win_t       fill_new;
  ptr_t       rd_addr;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign fill_base = in_series_start ? '0 : fill_r;
  assign sub_now   = (fill_base >= win_r);
  assign fill_new  = sub_now ? win_r : fill_base + win_t'(1);
  // A full-ring window wraps to the entry about to be overwritten.
  assign rd_addr   = wp_r - win_r[PTR_W-1:0];

  // Read returns the old entry when the same address is written this cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r         <= ring_mem[rd_addr];
      ring_mem[wp_r]    <= in_price;
    end
  end

  assign load_out = ((state_r == ST_DIV && div_rsp.done) || state_r == ST_WAIT) && out_free;

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_req.start    = 1'b0;
    div_req.dividend = sum_r;
    div_req.divisor  = win_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (cfg_wr_en) begin
          win_nxt  = win_eff(cfg_wr_data);
          sum_nxt  = '0;
          fill_nxt = '0;
        end
        if (accept) begin
          fill_nxt  = fill_new;
          wp_nxt    = wp_r + ptr_t'(1);
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt = (start_r ? '0 : sum_r) + sum_t'(sample_r)
                  - (sub_r ? sum_t'(rd_data_r) : '0);
        div_req.start    = emit_r;
        div_req.dividend = sum_nxt;
        state_nxt        = emit_r ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = out_free ? ST_IDLE : ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= win_t'(4);
      sum_r       <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_price;
      start_r  <= in_series_start;
      sub_r    <= sub_now;
      emit_r   <= (fill_new == win_r);
    end
    if (load_out) begin
      out_avg_r <= div_rsp.quotient;
    end
  end

  swa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid   = out_valid_r;
  assign out_average = out_avg_r;

endmodule

`default_nettype wire

// ===== rtl/swa_chk.sv =====
// ----------------------------------------------------------------------------
// swa_chk
// Port-level checks for the sliding window average block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_chk (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire swa_pkg::sample_t out_average
);

  // A result waiting on the receiver keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Only one transaction is in flight, so the input closes after each one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open in the cycle after a transaction");

  // The divider cannot finish in the cycle after a transaction is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind sliding_window_average swa_chk u_swa_chk (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds price samples to sliding_window_average under random idling on both
// channels and compares every average against a moving average that the
// bench keeps itself, across several window lengths and series restarts.
// ----------------------------------------------------------------------------

module tb_top;
  import swa_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_TARGET = 1830;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  sample_t in_price;
  logic    in_series_start;
  logic    out_valid;
  logic    out_stall;
  sample_t out_average;
  logic    cfg_wr_en;
  win_t    cfg_wr_data;

  // Bench copy of the window state.
  win_t    win_setting;
  sample_t price_hist [MAX_WINDOW];
  sum_t    win_sum;
  ptr_t    next_slot;
  win_t    samples_held;

  sample_t     expected_avg [$];
  sample_t     avg_due;
  int unsigned mismatches;
  int unsigned items_sent;
  bit          quiet;
  bit          long_hold_req;

  sliding_window_average dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_price        (in_price),
    .in_series_start (in_series_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("sliding_window_average test failed");
    $finish;
  end

  // Updates the window with one accepted sample and queues its average, if any.
  task automatic advance_window(input sample_t price, input logic start);
    win_t span;
    ptr_t oldest;
    if (win_setting == '0) begin
      span = win_t'(1);
    end else if (win_setting > win_t'(MAX_WINDOW)) begin
      span = win_t'(MAX_WINDOW);
    end else begin
      span = win_setting;
    end
    if (start) begin
      win_sum      = '0;
      samples_held = '0;
    end
    if (samples_held >= span) begin
      // A full ring of 256 wraps the oldest slot back onto the write slot.
      oldest       = next_slot - ptr_t'(span);
      win_sum      = win_sum - sum_t'(price_hist[oldest]);
      samples_held = span;
    end
    win_sum               = win_sum + sum_t'(price);
    price_hist[next_slot] = price;
    next_slot             = next_slot + ptr_t'(1);
    if (samples_held < span) begin
      samples_held = samples_held + win_t'(1);
    end
    if (samples_held == span) begin
      expected_avg = {expected_avg, sample_t'(win_sum / sum_t'(span))};
    end
  endtask

  task automatic send_sample(input sample_t price, input logic start);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_price        <= price;
    in_series_start <= start;
    do @(posedge clk); while (in_stall);
    advance_window(price, start);
    items_sent++;
  endtask

  // A sample that completes no window leaves no expectation behind, so the
  // bench also waits out a settling period for the block to finish with it.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_avg.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input win_t value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    win_setting  = value;
    win_sum      = '0;
    samples_held = '0;
  endtask

  function automatic sample_t random_price();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return sample_t'($urandom_range(0, 255));
      3:       return ~sample_t'($urandom_range(0, 255));
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_series(input win_t setting, input int unsigned count);
    int unsigned i;
    write_window(setting);
    for (i = 0; i < count; i++) begin
      send_sample(random_price(), $urandom_range(0, 3 * int'(setting) + 20) == 0);
    end
  endtask

  // The window length of four comes from reset alone.
  task automatic test_reset_window();
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample(sample_t'(32'h0000_0001), 1'b0);
  endtask

  task automatic test_window_edges();
    write_window(win_t'(1));
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample(sample_t'(32'h1234_5678), 1'b0);
    write_window('0);
    send_sample(sample_t'(32'hdead_beef), 1'b0);
    send_sample('1, 1'b0);
    // Two full-scale samples carry the sum past 32 bits.
    write_window(win_t'(2));
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample(sample_t'(32'h0000_0001), 1'b0);
  endtask

  task automatic test_series_start();
    write_window(win_t'(3));
    send_sample(sample_t'(32'h0000_0300), 1'b1);
    send_sample(sample_t'(32'h0000_0500), 1'b0);
    send_sample(sample_t'(32'h8000_0000), 1'b1);
    send_sample(sample_t'(32'h7fff_ffff), 1'b0);
    send_sample(sample_t'(32'h0000_0002), 1'b0);
    send_sample(sample_t'(32'hffff_0000), 1'b1);
    send_sample(sample_t'(32'h0000_ffff), 1'b1);
  endtask

  task automatic test_midseries_write();
    write_window(win_t'(3));
    send_sample(sample_t'(32'h0001_0000), 1'b0);
    send_sample(sample_t'(32'h0002_0000), 1'b0);
    write_window(win_t'(3));
    send_sample(sample_t'(32'h0000_0010), 1'b0);
    send_sample(sample_t'(32'h0000_0020), 1'b0);
    send_sample(sample_t'(32'h0000_0031), 1'b0);
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    int unsigned i;
    write_window(win_t'(1));
    long_hold_req = 1'b1;
    for (i = 0; i < 16; i++) begin
      send_sample(random_price(), 1'b0);
    end
  endtask

  task automatic test_random_windows();
    win_t        setting;
    int unsigned count;
    run_series(win_t'(MAX_WINDOW), MAX_WINDOW + 40);
    run_series('1, MAX_WINDOW + 30);
    while (items_sent < RANDOM_TARGET) begin
      if ($urandom_range(0, 5) == 0) begin
        setting = win_t'($urandom_range(17, 300));
        count   = (setting > win_t'(MAX_WINDOW)) ? MAX_WINDOW : int'(setting);
        count   = count + $urandom_range(10, 60);
      end else begin
        setting = win_t'($urandom_range(1, 16));
        count   = $urandom_range(30, 120);
      end
      run_series(setting, count);
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    run_series(win_t'($urandom_range(1, 8)), 100);
  endtask

  initial begin : receiver_idling
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_avg.size() == 0) begin
        $display("%0t: average with no transaction pending: expected none, actual %h",
                 $time, out_average);
        mismatches++;
      end else begin
        avg_due = expected_avg.pop_front();
        if (out_average !== avg_due) begin
          $display("%0t: average mismatch: expected %h, actual %h",
                   $time, avg_due, out_average);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_price        = '0;
    in_series_start = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    quiet           = 1'b0;
    long_hold_req   = 1'b0;
    mismatches      = 0;
    items_sent      = 0;
    win_setting     = win_t'(4);
    win_sum         = '0;
    next_slot       = '0;
    samples_held    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_window();
    test_window_edges();
    test_series_start();
    test_midseries_write();
    test_backpressure();
    test_random_windows();
    test_quiet_tail();

    wait_idle();
    if (mismatches == 0 && expected_avg.size() == 0) begin
      $display("sliding_window_average test passed");
    end else begin
      $display("sliding_window_average test failed");
    end
    $finish;
  end

endmodule
